### rtl/core/par_pkg.sv
// shared types and register map constants of the protection attribute register block
package par_pkg;

    // access kinds carried in tuser
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // register map, in word units
    localparam int ZONE_WORD_FIRST = 0;
    localparam int ZONE_WORDS      = 4;
    localparam int ATTR_WORD_FIRST = 4;
    localparam int ATTR_WORDS      = 8;
    localparam int LOCK_WORD_FIRST = 12;
    localparam int LOCK_WORDS      = 4;
    localparam int HWCFG_WORD      = 252;

    // packing of fields inside register words
    localparam int ATTRS_PER_WORD = 16;
    localparam int LOCKS_PER_WORD = 32;
    localparam int ZONE_LOCK_BIT  = 31;
    localparam int ATTR_SEL_W     = $clog2(ATTR_WORDS);
    localparam int LOCK_SEL_W     = $clog2(LOCK_WORDS);

    // one register access
    typedef struct packed {
        logic        opcode;
        logic [7:0]  word_index;
        logic [31:0] write_data;
    } t_req;

    // one access result
    typedef struct packed {
        logic [31:0] read_data;
        logic        write_refused;
    } t_rsp;

endpackage

### rtl/core/par_stage.sv
// pipeline register stage with valid/ready flow control
module par_stage #(
    parameter int W = 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_data
);
    logic         r_valid;
    logic [W-1:0] r_data;

    // stage can load when empty or when its beat leaves this cycle
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

endmodule

### rtl/core/par_regfile.sv
// protection attribute, lock and zone registers with read and masked write logic
module par_regfile #(
    parameter int NUM_PERIPH     = 96,
    parameter int NUM_ZONES      = 2,
    parameter int ZONE_SIZE_BITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  par_pkg::t_req i_req,
    input  logic        i_commit,
    output par_pkg::t_rsp o_rsp
);
    import par_pkg::*;

    localparam int ATTR_PAD = ATTR_WORDS * 32;
    localparam int LOCK_PAD = LOCK_WORDS * 32;

    logic [2*NUM_PERIPH-1:0]   r_attr, n_attr;
    logic [NUM_PERIPH-1:0]     r_plock, n_plock;
    logic [ZONE_SIZE_BITS-1:0] r_zsize [NUM_ZONES];
    logic [ZONE_SIZE_BITS-1:0] n_zsize [NUM_ZONES];
    logic [NUM_ZONES-1:0]      r_zlock, n_zlock;

    logic                  wr;
    logic                  is_zone, is_attr, is_lock, is_hw;
    logic [NUM_PERIPH-1:0] attr_refuse;
    logic [NUM_ZONES-1:0]  zone_refuse;
    logic [ATTR_PAD-1:0]   attr_pad;
    logic [LOCK_PAD-1:0]   lock_pad;
    logic [ATTR_SEL_W-1:0] attr_sel;
    logic [LOCK_SEL_W-1:0] lock_sel;
    logic [31:0]           zone_rd;
    logic [31:0]           rd;

    // address decode
    assign wr       = (i_req.opcode == OP_WRITE);
    assign is_zone  = i_req.word_index < ZONE_WORD_FIRST + ZONE_WORDS;
    assign is_attr  = i_req.word_index >= ATTR_WORD_FIRST &&
                      i_req.word_index < ATTR_WORD_FIRST + ATTR_WORDS;
    assign is_lock  = i_req.word_index >= LOCK_WORD_FIRST &&
                      i_req.word_index < LOCK_WORD_FIRST + LOCK_WORDS;
    assign is_hw    = i_req.word_index == HWCFG_WORD;
    assign attr_sel = ATTR_SEL_W'(i_req.word_index - 8'(ATTR_WORD_FIRST));
    assign lock_sel = LOCK_SEL_W'(i_req.word_index - 8'(LOCK_WORD_FIRST));

    // per peripheral attribute and lock update
    for (genvar p = 0; p < NUM_PERIPH; p++) begin : g_periph
        localparam int AW = ATTR_WORD_FIRST + p / ATTRS_PER_WORD;
        localparam int AK = p % ATTRS_PER_WORD;
        localparam int LW = LOCK_WORD_FIRST + p / LOCKS_PER_WORD;
        localparam int LK = p % LOCKS_PER_WORD;

        logic       attr_hit;
        logic       lock_hit;
        logic [1:0] a;

        assign attr_hit = wr && (i_req.word_index == AW);
        assign lock_hit = wr && (i_req.word_index == LW);
        assign a        = i_req.write_data[2*AK +: 2];

        // locked field keeps its value, refused only when it would change
        assign attr_refuse[p]   = attr_hit && r_plock[p] && (a != r_attr[2*p +: 2]);
        assign n_attr[2*p +: 2] = (attr_hit && !r_plock[p]) ? a : r_attr[2*p +: 2];
        // sticky lock: ones set, zeros ignored
        assign n_plock[p]       = r_plock[p] | (lock_hit & i_req.write_data[LK]);
    end

    // per zone size and lock update
    for (genvar z = 0; z < NUM_ZONES; z++) begin : g_zone
        logic                      hit;
        logic [ZONE_SIZE_BITS-1:0] sz;

        assign hit            = wr && (i_req.word_index == ZONE_WORD_FIRST + z);
        assign sz             = i_req.write_data[ZONE_SIZE_BITS-1:0];
        assign zone_refuse[z] = hit && r_zlock[z] && (sz != r_zsize[z]);
        assign n_zsize[z]     = (hit && !r_zlock[z]) ? sz : r_zsize[z];
        assign n_zlock[z]     = r_zlock[z] | (hit & i_req.write_data[ZONE_LOCK_BIT]);
    end

    // padded views so missing peripherals read as zero
    assign attr_pad = ATTR_PAD'(r_attr);
    assign lock_pad = LOCK_PAD'(r_plock);

    // zone word read
    always_comb begin
        zone_rd = '0;
        for (int z = 0; z < NUM_ZONES; z++) begin
            if (i_req.word_index == ZONE_WORD_FIRST + z) begin
                zone_rd = 32'(r_zsize[z]) | (32'(r_zlock[z]) << ZONE_LOCK_BIT);
            end
        end
    end

    // read data mux
    always_comb begin
        rd = '0;
        if (is_zone) begin
            rd = zone_rd;
        end else if (is_attr) begin
            rd = attr_pad[32*attr_sel +: 32];
        end else if (is_lock) begin
            rd = lock_pad[32*lock_sel +: 32];
        end else if (is_hw) begin
            rd = {16'b0, 8'(NUM_PERIPH), 8'(NUM_ZONES)};
        end
    end

    // result of this access
    assign o_rsp.read_data     = wr ? 32'b0 : rd;
    assign o_rsp.write_refused = wr && (!(is_zone || is_attr || is_lock) ||
                                        (|attr_refuse) || (|zone_refuse));

    // state registers, updated as the access retires
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr  <= '0;
            r_plock <= '0;
            r_zlock <= '0;
            for (int z = 0; z < NUM_ZONES; z++) begin
                r_zsize[z] <= '0;
            end
        end else if (i_commit) begin
            r_attr  <= n_attr;
            r_plock <= n_plock;
            r_zlock <= n_zlock;
            for (int z = 0; z < NUM_ZONES; z++) begin
                r_zsize[z] <= n_zsize[z];
            end
        end
    end

endmodule

### rtl/core/protection_attribute_register_block_unit.sv
// top level of the protection attribute register block: stream ports, access and result stages
//
//  channel   dir  beat contents
//  s_axis    in   tuser: opcode; tdata: word_index, write_data
//  m_axis    out  tdata: read_data, write_refused
//
// one access per cycle sustained while the output is not stalled; an input beat reaches
// the result beat through the access register, the register file logic and the result register.
// synchronous active-low reset clears all attributes, locks and zone sizes at once.
// a stalled result holds in the result register while the access register still
// takes one more beat; the input stalls only when both are full.
module protection_attribute_register_block_unit #(
    parameter int NUM_PERIPH     = 96,
    parameter int NUM_ZONES      = 2,
    parameter int ZONE_SIZE_BITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [7:0] word_index, [39:8] write_data
    input  logic [0:0]  s_axis_tuser,   // [0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // [31:0] read_data, [32] write_refused, rest zero
);
    import par_pkg::*;

    localparam int REQ_W = $bits(t_req);
    localparam int RSP_W = $bits(t_rsp);

    t_req in_req;
    t_req req;
    t_rsp rsp;
    t_rsp out_rsp;
    logic req_valid;
    logic out_ready;
    logic commit;

    // unpack the input beat
    assign in_req.opcode     = s_axis_tuser[0];
    assign in_req.word_index = s_axis_tdata[7:0];
    assign in_req.write_data = s_axis_tdata[39:8];

    // access register
    par_stage #(.W(REQ_W)) u_req_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (in_req),
        .o_valid (req_valid),
        .i_ready (out_ready),
        .o_data  (req)
    );

    // access retires when it moves into the result register
    assign commit = req_valid && out_ready;

    par_regfile #(
        .NUM_PERIPH     (NUM_PERIPH),
        .NUM_ZONES      (NUM_ZONES),
        .ZONE_SIZE_BITS (ZONE_SIZE_BITS)
    ) u_regfile (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (req),
        .i_commit (commit),
        .o_rsp    (rsp)
    );

    // result register
    par_stage #(.W(RSP_W)) u_rsp_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (req_valid),
        .o_ready (out_ready),
        .i_data  (rsp),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (out_rsp)
    );

    // pack the output beat
    assign m_axis_tdata = {7'b0, out_rsp.write_refused, out_rsp.read_data};

    // a new result beat appears only after an access retired
    a_no_invented_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(commit))
        else $error("result beat without retired access");

    // a retired read never reports a refused write
    a_read_not_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && req.opcode == OP_READ) |=> (m_axis_tdata[32] == 1'b0))
        else $error("read reported as refused write");

    // a retired write returns zero read data
    a_write_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && req.opcode == OP_WRITE) |=> (m_axis_tdata[31:0] == 32'b0))
        else $error("write returned nonzero read data");

endmodule
